>>> hdl/teq_pkg.sv
// Package for the timed event queue: shared constants, codes and the
// control bundle that the top level hands to every queue cell.
// Depends on nothing.
`default_nettype none
package teq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  localparam int TIME_W = 32;
  localparam int ITAG_W = 16;
  localparam int CNT_W  = 5;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_UNUSED  = 2'd3
  } teq_op_t;

  typedef enum logic [2:0] {
    KIND_ADDED    = 3'd0,
    KIND_PAST     = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_REMOVED  = 3'd3,
    KIND_RELEASED = 3'd4,
    KIND_NONE_DUE = 3'd5
  } teq_kind_t;

  typedef struct packed {
    logic              ins;
    logic              shl_all;
    logic              shl_ge;
    logic [TIME_W-1:0] ref_time;
  } teq_ctl_t;

endpackage
`default_nettype wire

>>> hdl/teq_cell.sv
// One slot of the sorted queue: holds a due time and a tag, compares the due time
// with the reference time and, on insert or shift, takes data from a neighbour or the new entry.
// Depends on teq_pkg.
`default_nettype none
module teq_cell
  import teq_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic                clk,
  input  wire teq_ctl_t            ctl,
  input  wire logic [TAG_BITS-1:0] new_tag,
  input  wire logic                occ,
  input  wire logic                left_le,
  input  wire logic [TIME_W-1:0]   left_due,
  input  wire logic [TAG_BITS-1:0] left_tag,
  input  wire logic [TIME_W-1:0]   right_due,
  input  wire logic [TAG_BITS-1:0] right_tag,
  output logic [TIME_W-1:0]        due,
  output logic [TAG_BITS-1:0]      tag,
  output logic                     le,
  output logic                     ge,
  output logic                     eq
);

  logic [TIME_W-1:0]   due_r, due_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;

  assign due = due_r;
  assign tag = tag_r;
  assign le  = occ && (due_r <= ctl.ref_time);
  assign ge  = occ && (due_r >= ctl.ref_time);
  assign eq  = occ && (due_r == ctl.ref_time);

  always_comb begin
    due_nxt = due_r;
    tag_nxt = tag_r;
    if (ctl.ins && !le) begin
      if (left_le) begin
        due_nxt = ctl.ref_time;
        tag_nxt = new_tag;
      end else begin
        due_nxt = left_due;
        tag_nxt = left_tag;
      end
    end else if (ctl.shl_all || (ctl.shl_ge && ge)) begin
      due_nxt = right_due;
      tag_nxt = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    due_r <= due_nxt;
    tag_r <= tag_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/timed_event_queue.sv
// Timed event queue: a row of sorted queue cells with a small controller.
// An add's result beat is registered and valid in the cycle after acceptance; a
// remove deletes one matching event per step, then gives its count once the result
// register is free; an advance releases due events, one per step, each waiting for
// the result register (a none-due beat if none is due). One item at a time.
// Reset clears the current time, the fill count, the state and the output valid.
`default_nettype none
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // time_value, event_tag
  input  wire logic [1:0]            in_tuser,  // opcode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata, // event_time, released_tag, removed_count
  output logic [2:0]                 out_tuser, // result_kind
  output logic                       out_tlast  // last_result
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_REMOVE  = 3'b010,
    ST_RELEASE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      rm_r, rm_nxt;
  logic [TIME_W-1:0]  cur_r, cur_nxt;
  logic [TIME_W-1:0]  tv_r, tv_nxt;

  logic               out_valid_r, out_valid_nxt;
  teq_kind_t          out_kind_r, out_kind_nxt;
  logic [TIME_W-1:0]  out_time_r, out_time_nxt;
  logic [ITAG_W-1:0]  out_tag_r, out_tag_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic               out_last_r, out_last_nxt;

  teq_ctl_t            ctl;
  logic [TIME_W-1:0]   in_time;
  logic [TAG_BITS-1:0] in_tag;
  teq_op_t             in_op;
  logic                out_free;
  logic                in_acc;
  logic                any_eq;

  logic [TIME_W-1:0]   due [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le, ge, eq;

  assign in_time  = in_tdata[31:0];
  assign in_tag   = TAG_BITS'(in_tdata[47:32]);
  assign in_op    = teq_op_t'(in_tuser);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_tvalid && in_tready;
  assign any_eq   = |eq;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_tag_r, out_time_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    teq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_tag   (in_tag),
      .occ       (CW'(i) < count_r),
      .left_le   ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
      .left_due  (due[(i == 0) ? 0 : i - 1]),
      .left_tag  (tag[(i == 0) ? 0 : i - 1]),
      .right_due (due[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .right_tag (tag[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .due       (due[i]),
      .tag       (tag[i]),
      .le        (le[i]),
      .ge        (ge[i]),
      .eq        (eq[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rm_nxt        = rm_r;
    cur_nxt       = cur_r;
    tv_nxt        = tv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_time_nxt  = out_time_r;
    out_tag_nxt   = out_tag_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;

    ctl.ins      = 1'b0;
    ctl.shl_all  = 1'b0;
    ctl.shl_ge   = 1'b0;
    ctl.ref_time = in_time;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_ADD: begin
              out_valid_nxt = 1'b1;
              out_time_nxt  = '0;
              out_tag_nxt   = '0;
              out_cnt_nxt   = '0;
              out_last_nxt  = 1'b1;
              if (in_time < cur_r) begin
                out_kind_nxt = KIND_PAST;
              end else if (count_r == CW'(QUEUE_DEPTH)) begin
                out_kind_nxt = KIND_FULL;
              end else begin
                ctl.ins      = 1'b1;
                count_nxt    = count_r + 1'b1;
                out_kind_nxt = KIND_ADDED;
              end
            end
            OP_REMOVE: begin
              tv_nxt    = in_time;
              rm_nxt    = '0;
              state_nxt = ST_REMOVE;
            end
            OP_ADVANCE: begin
              cur_nxt   = cur_r + in_time;
              state_nxt = ST_RELEASE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_REMOVE: begin
        ctl.ref_time = tv_r;
        if (any_eq) begin
          ctl.shl_ge = 1'b1;
          count_nxt  = count_r - 1'b1;
          rm_nxt     = rm_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_REMOVED;
          out_time_nxt  = '0;
          out_tag_nxt   = '0;
          out_cnt_nxt   = CNT_W'(rm_r);
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RELEASE: begin
        ctl.ref_time = cur_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = '0;
          if (le[0]) begin
            ctl.shl_all  = 1'b1;
            count_nxt    = count_r - 1'b1;
            out_kind_nxt = KIND_RELEASED;
            out_time_nxt = due[0];
            out_tag_nxt  = ITAG_W'(tag[0]);
            out_last_nxt = !le[1];
            if (!le[1]) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            out_kind_nxt = KIND_NONE_DUE;
            out_time_nxt = '0;
            out_tag_nxt  = '0;
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rm_r       <= rm_nxt;
    tv_r       <= tv_nxt;
    out_kind_r <= out_kind_nxt;
    out_time_r <= out_time_nxt;
    out_tag_r  <= out_tag_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire
